// ===== src/tart_pkg.sv =====
package tart_pkg;

  localparam int unsigned TYPE_W  = 2;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned PAGE_W  = 8;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned EXT_W   = 13;
  localparam int unsigned MIP_W   = 5;
  localparam int unsigned COORD_W = 17;
  localparam int unsigned TOT_W   = 32;
  // ceil(sqrt(2**COUNT_W - 1)) = 46 columns at most
  localparam int unsigned COL_W   = 6;
  localparam int unsigned SQ_W    = 12;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  localparam int unsigned TART_MAX_TILES  = 1024;
  localparam int unsigned TART_MAX_EXTENT = 4096;

  localparam logic [TYPE_W-1:0] REQ_TILE = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_PAGE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_COPY = 2'd2;

  localparam logic [1:0] REG_COUNT  = 2'd0;
  localparam logic [1:0] REG_EXTENT = 2'd1;
  localparam logic [1:0] REG_MIP    = 2'd2;

  localparam logic [MIP_W-1:0] MIP_ONE = 5'd1;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [IDX_W-1:0]  tile_index;
    logic [PAGE_W-1:0] page_number;
  } tart_in_t;

  typedef struct packed {
    logic               rect_valid;
    logic [COORD_W-1:0] rect_x;
    logic [COORD_W-1:0] rect_y;
    logic [EXT_W-1:0]   rect_width;
    logic [EXT_W-1:0]   rect_height;
    logic               need_page_alloc;
    logic               need_upload;
    logic [TOT_W-1:0]   hit_total;
    logic [TOT_W-1:0]   miss_total;
    logic [TOT_W-1:0]   alloc_total;
    logic [TOT_W-1:0]   copy_total;
  } tart_out_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic div_step;
    logic mul;
    logic commit;
  } tart_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic col_busy;
    logic rect_go;
    logic div_last;
    logic out_free;
  } tart_sts_t;

endpackage

// ===== src/tart_stream_if.sv =====
interface tart_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

// ===== src/tart_ctrl.sv =====
module tart_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tart_pkg::tart_sts_t sts,
  output tart_pkg::tart_cmd_t cmd
);
  import tart_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = !sts.col_busy;
        if (in_valid && !sts.col_busy) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = sts.rect_go ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

// ===== src/tart_dp.sv =====
module tart_dp #(
  parameter int unsigned MAX_TILES = tart_pkg::TART_MAX_TILES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tart_pkg::tart_in_t            in_word,
  input  tart_pkg::tart_cmd_t           cmd,
  output tart_pkg::tart_sts_t           sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tart_pkg::tart_out_t           out_word,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tart_pkg::ADDR_W-1:0]   paddr,
  input  logic [tart_pkg::DATA_W-1:0]   pwdata,
  output logic [tart_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import tart_pkg::*;

  localparam int unsigned IDX_SPAN = 2 ** IDX_W;
  localparam int unsigned DEPTH    = (MAX_TILES < IDX_SPAN) ? MAX_TILES : IDX_SPAN;
  localparam int unsigned AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DCNT_W   = $clog2(IDX_W);
  localparam int unsigned PX_W     = COL_W + EXT_W;
  localparam int unsigned PY_W     = IDX_W + EXT_W;

  // configuration
  logic [COUNT_W-1:0] count_r;
  logic [EXT_W-1:0]   extent_r;
  logic [MIP_W-1:0]   mip_r;
  logic [1:0]         reg_sel;
  logic               cfg_we;
  logic               cfg_hit;

  // column search
  logic [COL_W-1:0] col_r;
  logic [SQ_W-1:0]  sq_r;
  logic             col_busy_r;

  // item
  logic [TYPE_W-1:0] type_r;
  logic [IDX_W-1:0]  idx_r;
  logic [PAGE_W-1:0] page_r;
  logic              rd_r;

  // resident store
  logic          res_mem [DEPTH];
  logic [AW-1:0] clr_cnt_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;

  // divider
  logic [IDX_W-1:0]  q_r;
  logic [COL_W-1:0]  rem_r;
  logic [DCNT_W-1:0] div_cnt_r;
  logic [COL_W:0]    trial;
  logic              trial_ge;

  // products
  logic [PX_W-1:0]    px;
  logic [PY_W-1:0]    py;
  logic [COORD_W-1:0] rx_r;
  logic [COORD_W-1:0] ry_r;

  // state and counters
  logic             present_r;
  logic [TOT_W-1:0] hits_r;
  logic [TOT_W-1:0] misses_r;
  logic [TOT_W-1:0] allocs_r;
  logic [TOT_W-1:0] copies_r;
  logic             out_valid_r;
  tart_out_t        out_word_r;

  logic layout_ok;
  logic in_range;
  logic rect_go;
  logic copy_go;
  logic alloc_go;
  logic hit;
  logic miss;

  assign reg_sel = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_hit = cfg_we && (reg_sel == REG_COUNT || reg_sel == REG_EXTENT ||
                              reg_sel == REG_MIP);
  assign pready  = 1'b1;

  always_comb begin
    case (reg_sel)
      REG_COUNT:  prdata = DATA_W'(count_r);
      REG_EXTENT: prdata = DATA_W'(extent_r);
      REG_MIP:    prdata = DATA_W'(mip_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      extent_r <= '0;
      mip_r    <= MIP_ONE;
    end else if (cfg_we) begin
      case (reg_sel)
        REG_COUNT:  count_r  <= pwdata[COUNT_W-1:0];
        REG_EXTENT: extent_r <= pwdata[EXT_W-1:0];
        REG_MIP:    mip_r    <= pwdata[MIP_W-1:0];
        default:    ;
      endcase
    end
  end

  // columns = smallest c >= 1 with c*c >= count; squares stepped by 2c+1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= COL_W'(1);
      sq_r       <= SQ_W'(1);
      col_busy_r <= 1'b0;
    end else if (cfg_hit) begin
      col_r      <= COL_W'(1);
      sq_r       <= SQ_W'(1);
      col_busy_r <= 1'b1;
    end else if (col_busy_r) begin
      if (sq_r >= SQ_W'(count_r)) begin
        col_busy_r <= 1'b0;
      end else begin
        col_r <= col_r + COL_W'(1);
        sq_r  <= sq_r + SQ_W'({col_r, 1'b1});
      end
    end
  end

  assign layout_ok = (count_r != '0) && (32'(count_r) <= 32'(MAX_TILES)) &&
                     (extent_r != '0) && (32'(extent_r) <= 32'(TART_MAX_EXTENT)) &&
                     (mip_r == MIP_ONE);
  assign in_range  = (COUNT_W'(idx_r) < count_r) && (32'(idx_r) < 32'(MAX_TILES));
  assign rect_go   = (type_r == REQ_TILE) && layout_ok && in_range;
  assign copy_go   = (type_r == REQ_COPY) && layout_ok && in_range && !rd_r;
  assign alloc_go  = (type_r == REQ_PAGE) && (page_r == '0) && !present_r;
  assign hit       = rect_go && rd_r;
  assign miss      = rect_go && !rd_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r <= in_word.req_type;
      idx_r  <= in_word.tile_index;
      page_r <= in_word.page_number;
    end
  end

  assign mem_we = cmd.clr_step || (cmd.commit && copy_go);
  assign mem_wa = cmd.clr_step ? clr_cnt_r : idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      res_mem[mem_wa] <= !cmd.clr_step;
    end
    if (cmd.load) begin
      rd_r <= res_mem[in_word.tile_index[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= sts.clr_last ? '0 : clr_cnt_r + AW'(1);
    end
  end

  // restoring divide, one quotient bit per step
  assign trial    = {rem_r, q_r[IDX_W-1]};
  assign trial_ge = trial >= {1'b0, col_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.load) begin
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_r   <= in_word.tile_index;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? COL_W'(trial - {1'b0, col_r}) : COL_W'(trial);
      q_r   <= {q_r[IDX_W-2:0], trial_ge};
    end
  end

  assign px = PX_W'(rem_r) * PX_W'(extent_r);
  assign py = PY_W'(q_r) * PY_W'(extent_r);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rx_r <= px[COORD_W-1:0];
      ry_r <= py[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r   <= 1'b0;
      hits_r      <= '0;
      misses_r    <= '0;
      allocs_r    <= '0;
      copies_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        if (alloc_go) begin
          present_r <= 1'b1;
          allocs_r  <= allocs_r + TOT_W'(1);
        end
        if (hit) begin
          hits_r <= hits_r + TOT_W'(1);
        end
        if (miss) begin
          misses_r <= misses_r + TOT_W'(1);
        end
        if (copy_go) begin
          copies_r <= copies_r + TOT_W'(1);
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_word_r.rect_valid      <= rect_go;
      out_word_r.rect_x          <= rect_go ? rx_r : '0;
      out_word_r.rect_y          <= rect_go ? ry_r : '0;
      out_word_r.rect_width      <= rect_go ? extent_r : '0;
      out_word_r.rect_height     <= rect_go ? extent_r : '0;
      out_word_r.need_page_alloc <= miss && !present_r;
      out_word_r.need_upload     <= miss;
      out_word_r.hit_total       <= hits_r + TOT_W'(hit);
      out_word_r.miss_total      <= misses_r + TOT_W'(miss);
      out_word_r.alloc_total     <= allocs_r + TOT_W'(alloc_go);
      out_word_r.copy_total      <= copies_r + TOT_W'(copy_go);
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign sts.clr_last = (clr_cnt_r == AW'(DEPTH - 1));
  assign sts.col_busy = col_busy_r;
  assign sts.rect_go  = rect_go;
  assign sts.div_last = (div_cnt_r == DCNT_W'(IDX_W - 1));
  assign sts.out_free = !out_valid_r || out_ready;
endmodule

// ===== src/texture_atlas_residency_tracker_core.sv =====
// A tile request that returns a rectangle is loaded, evaluated, put through a 10-step
// index divide and a multiply, then committed once the output is free; other words go
// straight from evaluation to commit. No new request is taken until the last commits.
// After a write to the count, extent or mip register the column search holds off input.
// Reset (rst_n low, synchronous) clears counters and page state, then a clearing
// pass over min(MAX_TILES, 1024) entries wipes the resident marks before input is taken.
module texture_atlas_residency_tracker_core #(
  parameter int unsigned MAX_TILES = tart_pkg::TART_MAX_TILES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tart_stream_if.sink                 in_stream,
  tart_stream_if.source               out_stream,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tart_pkg::ADDR_W-1:0] paddr,
  input  logic [tart_pkg::DATA_W-1:0] pwdata,
  output logic [tart_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import tart_pkg::*;

  tart_cmd_t cmd;
  tart_sts_t sts;
  logic      in_ready;
  logic      out_valid;
  tart_out_t out_word;

  tart_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_stream.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tart_dp #(
    .MAX_TILES (MAX_TILES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_stream.word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_stream.ready),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  assign in_stream.ready  = in_ready;
  assign out_stream.valid = out_valid;
  assign out_stream.word  = out_word;
endmodule

// ===== src/tart_checker.sv =====
module tart_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input tart_pkg::tart_out_t out_word
);
  import tart_pkg::*;

  logic [1:0] pending_r;
  logic [1:0] pending_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pending_nxt = pending_r + 2'(in_acc) - 2'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // at most one item in work plus one word held at the output
  a_pending: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != 2'd3)
    else $error("more words in flight than the block can hold");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.rect_valid |->
      out_word.rect_x == '0 && out_word.rect_y == '0 &&
      out_word.rect_width == '0 && out_word.rect_height == '0 &&
      !out_word.need_page_alloc && !out_word.need_upload)
    else $error("empty result carries rectangle or flags");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.need_page_alloc |-> out_word.need_upload)
    else $error("page allocation asked without upload");

  a_square: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.rect_valid |->
      out_word.rect_width == out_word.rect_height && out_word.rect_width != '0)
    else $error("returned rectangle is not a nonempty square");
endmodule

bind texture_atlas_residency_tracker_core tart_checker u_tart_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_stream.valid),
  .in_ready  (in_stream.ready),
  .out_valid (out_stream.valid),
  .out_ready (out_stream.ready),
  .out_word  (out_stream.word)
);

// ===== tb/tart_residency_checker.sv =====
module tart_residency_checker
  import tart_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  tart_in_t          in_word,
  input  logic              out_valid,
  input  logic              out_ready,
  input  tart_out_t         out_word,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int unsigned       backlog,
  output int unsigned       fail_count,
  output int unsigned       words_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [COUNT_W-1:0] cfg_count;
  logic [EXT_W-1:0]   cfg_extent;
  logic [MIP_W-1:0]   cfg_mip;
  int unsigned        grid_cols;
  logic               resident [TART_MAX_TILES];
  logic               page_up;
  logic [TOT_W-1:0]   hits, misses, allocs, copies;
  tart_out_t          awaited_replies[$];
  int unsigned        fails;
  int unsigned        seen;

  function automatic int unsigned columns_for(int unsigned n);
    int unsigned c = 1;
    while (c < (n + c - 1) / c) c++;
    return c;
  endfunction

  function automatic logic layout_ok();
    return cfg_count != 0 && cfg_count <= TART_MAX_TILES &&
           cfg_extent != 0 && cfg_extent <= TART_MAX_EXTENT && cfg_mip == MIP_ONE;
  endfunction

  function automatic void clear_tracker();
    foreach (resident[i]) resident[i] = 1'b0;
    page_up    = 1'b0;
    cfg_count  = '0;
    cfg_extent = '0;
    cfg_mip    = MIP_ONE;
    hits       = '0;
    misses     = '0;
    allocs     = '0;
    copies     = '0;
    grid_cols  = columns_for(0);
  endfunction

  function automatic void apply_reg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    case (addr[ADDR_W-1:2])
      REG_COUNT:  cfg_count = data[COUNT_W-1:0];
      REG_EXTENT: cfg_extent = data[EXT_W-1:0];
      REG_MIP:    cfg_mip = data[MIP_W-1:0];
      default:    return;
    endcase
    grid_cols = columns_for(32'(cfg_count));
  endfunction

  // advance the tracker by one word and build its reply
  function automatic tart_out_t step_tracker(tart_in_t w);
    tart_out_t   r;
    logic        in_range;
    int unsigned col, row;
    r = '0;
    in_range = w.tile_index < cfg_count;
    case (w.req_type)
      REQ_TILE: begin
        if (layout_ok() && in_range) begin
          col           = 32'(w.tile_index) % grid_cols;
          row           = 32'(w.tile_index) / grid_cols;
          r.rect_valid  = 1'b1;
          r.rect_x      = COORD_W'(col * 32'(cfg_extent));
          r.rect_y      = COORD_W'(row * 32'(cfg_extent));
          r.rect_width  = cfg_extent;
          r.rect_height = cfg_extent;
          if (resident[w.tile_index]) begin
            hits++;
          end else begin
            misses++;
            r.need_upload     = 1'b1;
            r.need_page_alloc = !page_up;
          end
        end
      end
      REQ_PAGE: begin
        if (w.page_number == '0 && !page_up) begin
          page_up = 1'b1;
          allocs++;
        end
      end
      REQ_COPY: begin
        if (layout_ok() && in_range && !resident[w.tile_index]) begin
          resident[w.tile_index] = 1'b1;
          copies++;
        end
      end
      default: ;
    endcase
    r.hit_total   = hits;
    r.miss_total  = misses;
    r.alloc_total = allocs;
    r.copy_total  = copies;
    return r;
  endfunction

  task automatic cmp(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  task automatic check_reply(tart_out_t want, tart_out_t got);
    cmp("rect_valid", 32'(want.rect_valid), 32'(got.rect_valid));
    cmp("rect_x", 32'(want.rect_x), 32'(got.rect_x));
    cmp("rect_y", 32'(want.rect_y), 32'(got.rect_y));
    cmp("rect_width", 32'(want.rect_width), 32'(got.rect_width));
    cmp("rect_height", 32'(want.rect_height), 32'(got.rect_height));
    cmp("need_page_alloc", 32'(want.need_page_alloc), 32'(got.need_page_alloc));
    cmp("need_upload", 32'(want.need_upload), 32'(got.need_upload));
    cmp("hit_total", want.hit_total, got.hit_total);
    cmp("miss_total", want.miss_total, got.miss_total);
    cmp("alloc_total", want.alloc_total, got.alloc_total);
    cmp("copy_total", want.copy_total, got.copy_total);
  endtask

  initial begin
    fails = 0;
    seen  = 0;
    clear_tracker();
  end

  always @(posedge clk) begin
    tart_out_t want;
    tart_out_t fresh;
    if (!rst_n) begin
      clear_tracker();
      awaited_replies.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen++;
        if (awaited_replies.size() == 0) begin
          $error("reply word with nothing outstanding");
          fails++;
        end else begin
          want = awaited_replies.pop_front();
          check_reply(want, out_word);
        end
      end
      if (in_valid && in_ready) begin
        fresh = step_tracker(in_word);
        awaited_replies.insert(awaited_replies.size(), fresh);
      end
      if (psel && penable && pwrite && pready) apply_reg_write(paddr, pwdata);
    end
    backlog    <= awaited_replies.size();
    fail_count <= fails;
    words_seen <= seen;
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tart_pkg::*;

  localparam logic [TYPE_W-1:0] REQ_BAD  = 2'd3;
  localparam logic [1:0]        REG_NONE = 2'd3;
  localparam int                PHASES   = 12;
  localparam int                PHASE_LEN = 102;

  logic              clk;
  logic              rst_n;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              steady;
  int unsigned       backlog, fail_count, words_seen;
  int unsigned       items_sent, layouts;

  tart_stream_if #(.word_t(tart_in_t))  in_if ();
  tart_stream_if #(.word_t(tart_out_t)) out_if ();

  texture_atlas_residency_tracker_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_if),
    .out_stream (out_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  tart_residency_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_word    (in_if.word),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_word   (out_if.word),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .backlog    (backlog),
    .fail_count (fail_count),
    .words_seen (words_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_item(logic [TYPE_W-1:0] kind, logic [IDX_W-1:0] idx,
                           logic [PAGE_W-1:0] page);
    int unsigned gap;
    tart_in_t    w;
    gap = steady ? 0 : $urandom_range(0, 3);
    w.req_type    = kind;
    w.tile_index  = idx;
    w.page_number = page;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.word  <= w;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every reply is back, plus the block's own tail
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_layout(int unsigned count, int unsigned extent, int unsigned mip);
    drain();
    write_reg(REG_COUNT, count);
    write_reg(REG_EXTENT, extent);
    write_reg(REG_MIP, mip);
    layouts++;
  endtask

  task automatic send_random(int unsigned count);
    int unsigned       pick, top_idx;
    logic [IDX_W-1:0]  idx;
    logic [PAGE_W-1:0] page;
    pick    = $urandom_range(0, 99);
    top_idx = (count != 0 && count <= TART_MAX_TILES) ? count - 1 : TART_MAX_TILES - 1;
    idx     = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, top_idx));
    page    = $urandom_range(0, 1) ? PAGE_W'(0) : PAGE_W'($urandom_range(0, 255));
    if (pick < 50) send_item(REQ_TILE, idx, page);
    else if (pick < 85) send_item(REQ_COPY, idx, page);
    else if (pick < 95) send_item(REQ_PAGE, idx, page);
    else send_item(REQ_BAD, idx, page);
  endtask

  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      int unsigned stall;
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  initial begin
    int unsigned count, extent, mip;
    rst_n       = 1'b0;
    steady      = 1'b0;
    items_sent  = 0;
    layouts     = 0;
    in_if.valid <= 1'b0;
    in_if.word  <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset layout is empty: nothing returns a rectangle
    send_item(REQ_TILE, 10'd0, 8'd0);
    send_item(REQ_COPY, 10'd0, 8'd0);
    send_item(REQ_BAD, 10'h3FF, 8'hFF);

    set_layout(TART_MAX_TILES, TART_MAX_EXTENT, 32'(MIP_ONE));
    send_item(REQ_TILE, 10'h3FF, 8'hFF);
    send_item(REQ_TILE, 10'd0, 8'd0);
    send_item(REQ_PAGE, 10'd0, 8'hFF);
    send_item(REQ_PAGE, 10'd0, 8'd0);
    send_item(REQ_PAGE, 10'd0, 8'd0);
    send_item(REQ_TILE, 10'd0, 8'd0);
    send_item(REQ_COPY, 10'd0, 8'd0);
    send_item(REQ_COPY, 10'd0, 8'd0);
    send_item(REQ_TILE, 10'd0, 8'd0);
    send_item(REQ_COPY, 10'h3FF, 8'd0);
    send_item(REQ_TILE, 10'h3FF, 8'd0);
    send_item(REQ_BAD, 10'd0, 8'd0);
    send_item(REQ_TILE, 10'h2AA, 8'hAA);
    send_item(REQ_COPY, 10'h155, 8'h55);

    set_layout(1, 1, 32'(MIP_ONE));
    send_item(REQ_TILE, 10'd0, 8'd0);
    send_item(REQ_TILE, 10'd1, 8'd0);
    send_item(REQ_COPY, 10'd5, 8'd0);
    send_item(REQ_TILE, 10'd5, 8'd0);

    set_layout(TART_MAX_TILES, TART_MAX_EXTENT, 2);
    send_item(REQ_TILE, 10'd3, 8'd0);
    send_item(REQ_COPY, 10'd3, 8'd0);

    set_layout(2047, 8191, 32'(MIP_ONE));
    send_item(REQ_TILE, 10'd100, 8'd0);
    send_item(REQ_COPY, 10'd100, 8'd0);

    set_layout(TART_MAX_TILES, 0, 32'(MIP_ONE));
    send_item(REQ_TILE, 10'd2, 8'd0);

    drain();
    write_reg(REG_NONE, $urandom);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin count = TART_MAX_TILES; extent = TART_MAX_EXTENT; mip = 32'(MIP_ONE); end
        1: begin count = 1; extent = TART_MAX_EXTENT; mip = 32'(MIP_ONE); end
        2: begin count = TART_MAX_TILES; extent = 1; mip = 32'(MIP_ONE); end
        3: begin count = 2; extent = 7; mip = 32'(MIP_ONE); end
        4: begin count = 1000; extent = 4095; mip = 32'(MIP_ONE); end
        default: begin
          count  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                               : $urandom_range(1, TART_MAX_TILES);
          extent = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                               : $urandom_range(1, TART_MAX_EXTENT);
          mip    = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 31) : 32'(MIP_ONE);
        end
      endcase
      set_layout(count, extent, mip);
      steady = (p % 4 == 3);
      repeat (PHASE_LEN) send_random(count);
    end

    drain();
    $display("Sent %0d items across %0d layouts; %0d reply words checked.",
             items_sent, layouts, words_seen);
    if (fail_count == 0 && backlog == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
